// ===== rtl/core/hfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types and constants for the hash frequency counter.
// ----------------------------------------------------------------------------
package hfc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int OCC_W       = IDX_W + 1;

    localparam logic [1:0] OP_COUNT = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_INCR    = 3'd0;
    localparam logic [2:0] ST_INSERT  = 3'd1;
    localparam logic [2:0] ST_EVICTED = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    localparam logic [1:0] FLAG_EMPTY      = 2'd0;
    localparam logic [1:0] FLAG_REGISTERED = 2'd1;
    localparam logic [1:0] FLAG_DELETED    = 2'd2;

    localparam logic [1:0] REG_HIGH_WATER = 2'd0;
    localparam logic [1:0] REG_LOW_WATER  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key_hash;
        logic [11:0] slot_index;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  slot_used;
        logic [11:0] slot_position;
        logic [1:0]  entry_state;
        logic [63:0] entry_hash;
        logic [31:0] entry_count;
        logic        entry_frequent;
        logic [12:0] occupancy;
    } t_out;

    typedef struct packed {
        logic [1:0]  flag;
        logic [63:0] key;
        logic [31:0] count;
    } t_entry;

endpackage

// ===== rtl/core/hfc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfc_ram
// Single-port table memory with registered read data.
// ----------------------------------------------------------------------------
module hfc_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 98
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== rtl/core/hash_frequency_counter_with_eviction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_frequency_counter_with_eviction
// Linear-probing frequency counter over a 4096-slot table with eviction.
// ----------------------------------------------------------------------------
// One operation at a time; all table work goes through one single-port
// memory, each slot visited in an address state, then a data state with
// registered read data. A count probes slots and writes back in a write
// state; a read passes one address and one data state. An eviction runs
// whole-table sweeps: a delete pass, then per further pass a minimum
// search sweep and a delete sweep. A clear, and the pass after reset,
// sweeps 4096 slots at one per cycle and takes no transaction meanwhile.
// The input side stays closed while a result waits in the result register.
module hash_frequency_counter_with_eviction (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hfc_pkg::t_in       i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output hfc_pkg::t_out      o_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int IW = hfc_pkg::IDX_W;
    localparam int OW = hfc_pkg::OCC_W;
    localparam int EW = $bits(hfc_pkg::t_entry);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FK_A, S_FK_D, S_WR, S_EV_A, S_EV_D,
        S_MN_A, S_MN_D, S_FF_A, S_FF_D, S_RD_A, S_RD_D, S_DONE
    } t_state;

    t_state                 r_state;
    logic [IW-1:0]          r_addr;
    logic [IW:0]            r_cnt;
    logic [63:0]            r_key;
    logic [31:0]            r_limit;
    logic [31:0]            r_least;
    logic                   r_evicted;
    logic                   r_clear;
    logic [2:0]             r_st;
    logic [OW-1:0]          r_occ;
    logic [12:0]            r_high;
    logic [12:0]            r_low;
    logic [31:0]            r_thr;
    logic                   r_ovalid;
    hfc_pkg::t_out          r_out;
    hfc_pkg::t_entry        r_wentry;

    logic                   w_we;
    logic [EW-1:0]          w_wdata;
    logic [EW-1:0]          w_rdata;
    hfc_pkg::t_entry        w_e;
    logic                   w_last;

    assign w_e    = hfc_pkg::t_entry'(w_rdata);
    assign w_last = (r_cnt == (IW+1)'(hfc_pkg::TABLE_DEPTH - 1));

    always_comb begin
        w_we    = 1'b0;
        w_wdata = EW'(r_wentry);
        case (r_state)
            S_INIT:  begin
                w_we    = 1'b1;
                w_wdata = '0;
            end
            S_WR:    w_we = 1'b1;
            S_EV_D:  begin
                w_we    = (w_e.flag == hfc_pkg::FLAG_REGISTERED) && (w_e.count <= r_limit);
                w_wdata = EW'({hfc_pkg::FLAG_DELETED, w_e.key, w_e.count});
            end
            default: w_we = 1'b0;
        endcase
    end

    hfc_ram #(.DEPTH(hfc_pkg::TABLE_DEPTH), .WIDTH(EW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (r_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    function automatic hfc_pkg::t_out f_rep(logic [2:0] st, logic [IW-1:0] pos,
                                            hfc_pkg::t_entry e, logic [31:0] thr,
                                            logic [OW-1:0] occ);
        hfc_pkg::t_out o;
        o                = '0;
        o.status         = st;
        o.slot_used      = pos[1:0];
        o.slot_position  = 12'(pos);
        o.entry_state    = e.flag;
        o.entry_hash     = e.key;
        o.entry_count    = e.count;
        o.entry_frequent = (e.flag == hfc_pkg::FLAG_REGISTERED) && (e.count >= thr);
        o.occupancy      = 13'(occ);
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_addr   <= '0;
            r_cnt    <= '0;
            r_occ    <= '0;
            r_high   <= 13'd3072;
            r_low    <= 13'd2048;
            r_thr    <= 32'd2;
            r_ovalid <= 1'b0;
            r_clear  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hfc_pkg::REG_HIGH_WATER: r_high <= i_cfg_data[12:0];
                    hfc_pkg::REG_LOW_WATER:  r_low  <= i_cfg_data[12:0];
                    hfc_pkg::REG_THRESHOLD:  r_thr  <= i_cfg_data;
                    default:                 r_thr  <= r_thr;
                endcase
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == IW'(hfc_pkg::TABLE_DEPTH - 1)) begin
                        r_occ <= '0;
                        if (r_clear) begin
                            r_out   <= f_rep(hfc_pkg::ST_CLEARED, '0, '0, r_thr, '0);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                        r_clear <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_key     <= i_data.key_hash;
                        r_cnt     <= '0;
                        r_evicted <= 1'b0;
                        case (i_data.operation)
                            hfc_pkg::OP_COUNT: begin
                                r_addr  <= i_data.key_hash[IW-1:0];
                                r_state <= S_FK_A;
                            end
                            hfc_pkg::OP_READ: begin
                                r_addr  <= i_data.slot_index[IW-1:0];
                                r_state <= S_RD_A;
                            end
                            hfc_pkg::OP_CLEAR: begin
                                r_addr  <= '0;
                                r_clear <= 1'b1;
                                r_state <= S_INIT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FK_A: r_state <= S_FK_D;
                S_FK_D: begin
                    if (w_e.flag == hfc_pkg::FLAG_REGISTERED && w_e.key == r_key) begin
                        r_wentry <= '{flag: w_e.flag, key: w_e.key,
                                      count: (w_e.count == '1) ? w_e.count
                                                               : w_e.count + 1'b1};
                        r_st     <= hfc_pkg::ST_INCR;
                        r_state  <= S_WR;
                    end else if (w_e.flag == hfc_pkg::FLAG_EMPTY || w_last) begin
                        r_cnt <= '0;
                        if (13'(r_occ) >= r_high) begin
                            r_evicted <= 1'b1;
                            r_limit   <= 32'd1;
                            r_addr    <= '0;
                            r_state   <= S_EV_A;
                        end else begin
                            r_addr  <= r_key[IW-1:0];
                            r_state <= S_FF_A;
                        end
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_FK_A;
                    end
                end
                S_EV_A: r_state <= S_EV_D;
                S_EV_D: begin
                    if (w_we) begin
                        r_occ <= r_occ - 1'b1;
                    end
                    if (w_last) begin
                        r_cnt   <= '0;
                        r_least <= '1;
                        if (((13'(r_occ - OW'(w_we))) >= r_low) &&
                            (r_occ - OW'(w_we) != '0)) begin
                            r_addr  <= '0;
                            r_state <= S_MN_A;
                        end else begin
                            r_addr  <= r_key[IW-1:0];
                            r_state <= S_FF_A;
                        end
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_EV_A;
                    end
                end
                S_MN_A: r_state <= S_MN_D;
                S_MN_D: begin
                    if (w_last) begin
                        r_cnt   <= '0;
                        r_addr  <= '0;
                        r_limit <= (w_e.flag == hfc_pkg::FLAG_REGISTERED &&
                                    w_e.count < r_least) ? w_e.count : r_least;
                        r_state <= S_EV_A;
                    end else begin
                        if (w_e.flag == hfc_pkg::FLAG_REGISTERED && w_e.count < r_least) begin
                            r_least <= w_e.count;
                        end
                        r_addr  <= r_addr + 1'b1;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_MN_A;
                    end
                end
                S_FF_A: r_state <= S_FF_D;
                S_FF_D: begin
                    if (w_e.flag != hfc_pkg::FLAG_REGISTERED) begin
                        r_wentry <= '{flag: hfc_pkg::FLAG_REGISTERED, key: r_key,
                                      count: 32'd1};
                        r_st     <= r_evicted ? hfc_pkg::ST_EVICTED : hfc_pkg::ST_INSERT;
                        r_occ    <= r_occ + 1'b1;
                        r_state  <= S_WR;
                    end else if (w_last) begin
                        r_out   <= f_rep(hfc_pkg::ST_FULL, '0, '0, r_thr, r_occ);
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_FF_A;
                    end
                end
                S_WR: begin
                    r_out   <= f_rep(r_st, r_addr, r_wentry, r_thr, r_occ);
                    r_state <= S_DONE;
                end
                S_RD_A: r_state <= S_RD_D;
                S_RD_D: begin
                    r_out   <= f_rep(hfc_pkg::ST_READ, r_addr, w_e, r_thr, r_occ);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("ready while busy");
    a_in_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("ready while a result waits");
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(hfc_pkg::TABLE_DEPTH))
        else $error("occupancy overflow");
`endif

endmodule
